@@ hdl/bat_pkg.sv @@
// Shared constants, codes, types and helper functions of the buddy allocator tree.
package bat_pkg;

  localparam int unsigned TotalUnits = 1024;
  localparam int unsigned Levels     = 10;
  localparam int unsigned NodeW      = 11;
  localparam int unsigned SizeW      = 11;
  localparam int unsigned OffW       = 10;
  localparam int unsigned LvlW       = 4;
  localparam int unsigned Slots      = 11;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned NodeCount  = 2 * TotalUnits - 1;

  localparam logic [1:0] OPC_ALLOC = 2'd0;
  localparam logic [1:0] OPC_FREE  = 2'd1;
  localparam logic [1:0] OPC_QUERY = 2'd2;
  localparam logic [1:0] OPC_INIT  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_BAD_ARG   = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_PAT_N, OP_PAT_USE, OP_PAT_REM, OP_BIT_DEC,
    OP_RD_ROOT, OP_RD_LEFT, OP_DESCEND, OP_TAKE_WR, OP_RD_SIB, OP_UP_TAKE,
    OP_UP_REL, OP_IX_CLR, OP_LEAF_IN, OP_LEAF_HELD, OP_RD_NODE, OP_FIND_UP,
    OP_REL_WR, OP_SET_RES, OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {EM_PLAIN, EM_RES, EM_CHUNK} emit_e;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_ICLR, S_IPAT, S_BIT, S_STEP, S_CHK, S_DESC,
    S_DCHK, S_TUP, S_TUPW, S_REL, S_FRD, S_FCHK, S_RUP, S_RUPW,
    S_OUT_ZERO, S_OUT_FAIL, S_OUT_RES, S_OUT_CHUNK
  } state_e;

  typedef enum logic [2:0] {
    PH_ALLOC, PH_INIT_USE, PH_INIT_REM, PH_INIT_REL, PH_ROLL, PH_FREE, PH_QUERY
  } phase_e;

  typedef struct packed {
    dp_op_e     op;
    logic       push;
    emit_e      kind;
    logic [1:0] status;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       fit;
    logic       at_target;
    logic       at_root;
    logic       bit_set;
    logic       bit_zero;
    logic       zero;
    logic       ix_end;
    logic       chunk_last;
    logic       cnt_zero;
    logic       out_free;
    logic [1:0] opcode;
  } sts_t;

  // Depth of a heap node, numbered from zero at the root.
  function automatic logic [LvlW-1:0] node_level(logic [NodeW-1:0] h);
    logic [LvlW-1:0] r;
    r = '0;
    for (int i = 0; i < NodeW; i++) begin
      if (h[i]) begin
        r = LvlW'(i);
      end
    end
    return r;
  endfunction

  // Value of a node in a fully free tree.
  function automatic logic [SizeW-1:0] full_size(logic [NodeW-1:0] h);
    return SizeW'(TotalUnits) >> node_level(h);
  endfunction

endpackage

@@ hdl/bat_dpath.sv @@
// Datapath: tree memory, walk registers, chunk store and output register.
module bat_dpath import bat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        operation_i,
  input  logic [SizeW-1:0]  unit_count_i,
  input  logic [OffW-1:0]   offset_i,
  input  logic              cfg_valid_i,
  input  logic [SizeW-1:0]  usable_units_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [OffW-1:0]   chunk_offset_o,
  output logic [SizeW-1:0]  chunk_size_o,
  output logic              last_o
);

  logic [SizeW-1:0] tree_mem [1:NodeCount];
  logic [SizeW-1:0] rdata_q;
  logic             we, rd;
  logic [NodeW-1:0] waddr, raddr;
  logic [SizeW-1:0] wdata;

  logic [NodeW-1:0] clr_q, clr_d, h_q, h_d;
  logic [LvlW-1:0]  lg_q, lg_d, bit_q, bit_d;
  logic [SizeW-1:0] v_q, v_d, pat_q, pat_d, usable_q, usable_d;
  logic [SlotW-1:0] tc_q, tc_d, ix_q, ix_d;
  logic [OffW-1:0]  offs_q [Slots];
  logic [LvlW-1:0]  lgs_q [Slots];
  logic             push_en;
  logic [OffW-1:0]  res_off_q, res_off_d;
  logic [SizeW-1:0] res_size_q, res_size_d;
  logic [1:0]       opc_q;
  logic [SizeW-1:0] cnt_q;
  logic [OffW-1:0]  in_off_q;
  logic             out_valid_q, out_valid_d, last_q, last_d;
  logic [1:0]       status_q, status_d;
  logic [OffW-1:0]  coff_q, coff_d;
  logic [SizeW-1:0] csize_q, csize_d;

  logic [SizeW-1:0]      req_size, lvl_size, up_size, up_max, usable_lim, rel_val;
  logic [SizeW:0]        up_sum;
  logic [NodeW-1:0]      parent;
  logic [OffW+NodeW-1:0] off_wide;
  logic [OffW-1:0]       node_off;
  logic                  out_free;

  assign req_size   = SizeW'(1) << bit_q;
  assign lvl_size   = SizeW'(1) << lg_q;
  assign up_size    = SizeW'(1) << (lg_q + 4'd1);
  assign parent     = h_q >> 1;
  assign up_max     = (v_q > rdata_q) ? v_q : rdata_q;
  assign up_sum     = {1'b0, v_q} + {1'b0, rdata_q};
  assign rel_val    = (up_sum == {1'b0, up_size}) ? up_size : up_max;
  assign off_wide   = {{OffW{1'b0}}, h_q} << lg_q;
  assign node_off   = off_wide[OffW-1:0];
  assign usable_lim = (usable_q > SizeW'(TotalUnits)) ? SizeW'(TotalUnits) : usable_q;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.clr_last   = (clr_q == NodeW'(NodeCount));
    sts_o.fit        = (rdata_q >= req_size);
    sts_o.at_target  = (lg_q == bit_q);
    sts_o.at_root    = (h_q == NodeW'(1));
    sts_o.bit_set    = pat_q[bit_q];
    sts_o.bit_zero   = (bit_q == '0);
    sts_o.zero       = (rdata_q == '0);
    sts_o.ix_end     = (ix_q == tc_q);
    sts_o.chunk_last = ((ix_q + 4'd1) == tc_q);
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.out_free   = out_free;
    sts_o.opcode     = opc_q;
  end

  always_comb begin
    we = 1'b0;  rd = 1'b0;  waddr = h_q;  raddr = h_q;  wdata = '0;
    clr_d = clr_q;  h_d = h_q;  lg_d = lg_q;  bit_d = bit_q;  v_d = v_q;
    pat_d = pat_q;  tc_d = tc_q;  ix_d = ix_q;  push_en = 1'b0;
    res_off_d = res_off_q;  res_size_d = res_size_q;
    usable_d = cfg_valid_i ? usable_units_i : usable_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d = status_q;  coff_d = coff_q;  csize_d = csize_q;  last_d = last_q;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_CLEAR: begin
        we = 1'b1;  waddr = clr_q;  wdata = full_size(clr_q);
        clr_d = sts_o.clr_last ? NodeW'(1) : clr_q + 11'd1;
      end
      OP_PAT_N: begin
        pat_d = cnt_q;  bit_d = LvlW'(Levels);  tc_d = '0;  ix_d = '0;
      end
      OP_PAT_USE: begin
        pat_d = usable_lim;  bit_d = LvlW'(Levels);  tc_d = '0;
      end
      OP_PAT_REM: begin
        pat_d = SizeW'(TotalUnits) - usable_lim;  bit_d = LvlW'(Levels);
      end
      OP_BIT_DEC: bit_d = bit_q - 4'd1;
      OP_RD_ROOT: begin
        rd = 1'b1;  raddr = NodeW'(1);  h_d = NodeW'(1);  lg_d = LvlW'(Levels);
      end
      OP_RD_LEFT: begin
        rd = 1'b1;  raddr = h_q << 1;
      end
      OP_DESCEND: begin
        h_d = {h_q[NodeW-2:0], (rdata_q < req_size)};  lg_d = lg_q - 4'd1;
      end
      OP_TAKE_WR: begin
        we = 1'b1;  waddr = h_q;  wdata = '0;  v_d = '0;
        if (cmd_i.push) begin
          push_en = 1'b1;  tc_d = tc_q + 4'd1;
        end
      end
      OP_RD_SIB: begin
        rd = 1'b1;  raddr = h_q ^ NodeW'(1);
      end
      OP_UP_TAKE: begin
        we = 1'b1;  waddr = parent;  wdata = up_max;
        h_d = parent;  v_d = up_max;  lg_d = lg_q + 4'd1;
      end
      OP_UP_REL: begin
        we = 1'b1;  waddr = parent;  wdata = rel_val;
        h_d = parent;  v_d = rel_val;  lg_d = lg_q + 4'd1;
      end
      OP_IX_CLR: ix_d = '0;
      OP_LEAF_IN: begin
        h_d = {1'b1, in_off_q};  lg_d = '0;
      end
      OP_LEAF_HELD: begin
        h_d = {1'b1, offs_q[ix_q]};  lg_d = '0;  ix_d = ix_q + 4'd1;
      end
      OP_RD_NODE: begin
        rd = 1'b1;  raddr = h_q;
      end
      OP_FIND_UP: begin
        h_d = parent;  lg_d = lg_q + 4'd1;
      end
      OP_REL_WR: begin
        we = 1'b1;  waddr = h_q;  wdata = lvl_size;  v_d = lvl_size;
        res_off_d = node_off;  res_size_d = lvl_size;
      end
      OP_SET_RES: begin
        res_off_d = node_off;  res_size_d = lvl_size;
      end
      OP_EMIT: begin
        out_valid_d = 1'b1;
        unique case (cmd_i.kind)
          EM_PLAIN: begin
            status_d = cmd_i.status;  coff_d = '0;  csize_d = '0;  last_d = 1'b1;
          end
          EM_RES: begin
            status_d = ST_OK;  coff_d = res_off_q;  csize_d = res_size_q;  last_d = 1'b1;
          end
          EM_CHUNK: begin
            status_d = ST_OK;  coff_d = offs_q[ix_q];
            csize_d = SizeW'(1) << lgs_q[ix_q];
            last_d = sts_o.chunk_last;  ix_d = ix_q + 4'd1;
          end
          default: last_d = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      tree_mem[waddr] <= wdata;
    end
    if (rd) begin
      rdata_q <= tree_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= NodeW'(1);  h_q <= NodeW'(1);  lg_q <= '0;  bit_q <= '0;
      tc_q <= '0;  ix_q <= '0;  out_valid_q <= 1'b0;
      usable_q <= SizeW'(TotalUnits);
    end else begin
      clr_q <= clr_d;  h_q <= h_d;  lg_q <= lg_d;  bit_q <= bit_d;
      tc_q <= tc_d;  ix_q <= ix_d;  out_valid_q <= out_valid_d;
      usable_q <= usable_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;  pat_q <= pat_d;
    res_off_q <= res_off_d;  res_size_q <= res_size_d;
    status_q <= status_d;  coff_q <= coff_d;  csize_q <= csize_d;  last_q <= last_d;
    if (push_en) begin
      offs_q[tc_q] <= node_off;
      lgs_q[tc_q]  <= lg_q;
    end
    if (cmd_i.load) begin
      opc_q <= operation_i;  cnt_q <= unit_count_i;  in_off_q <= offset_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign chunk_offset_o = coff_q;
  assign chunk_size_o   = csize_q;
  assign last_o         = last_q;

  a_tc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_q <= SlotW'(Slots)) else $error("chunk store overflow");
  a_node_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_q != '0) else $error("walk left the heap");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_EMIT |-> out_free) else $error("result overwritten");
  a_no_dual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && rd)) else $error("tree memory read and written together");

endmodule

@@ hdl/bat_ctrl.sv @@
// Controller: sequences tree walks, chunk splitting, rollback and result beats.
module bat_ctrl import bat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      phase_q <= PH_ALLOC;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o.op = OP_NONE;
    cmd_o.push = (phase_q != PH_INIT_REM);
    cmd_o.kind = EM_PLAIN;
    cmd_o.status = ST_OK;
    cmd_o.load = 1'b0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_CLR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.opcode)
          OPC_ALLOC: begin
            phase_d = PH_ALLOC;
            if (sts_i.cnt_zero) begin
              state_d = S_OUT_ZERO;
            end else begin
              cmd_o.op = OP_PAT_N;
              state_d = S_BIT;
            end
          end
          OPC_FREE: begin
            phase_d = PH_FREE;  cmd_o.op = OP_LEAF_IN;  state_d = S_FRD;
          end
          OPC_QUERY: begin
            phase_d = PH_QUERY;  cmd_o.op = OP_LEAF_IN;  state_d = S_FRD;
          end
          OPC_INIT: begin
            phase_d = PH_INIT_USE;  state_d = S_ICLR;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ICLR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IPAT;
      end
      S_IPAT: begin
        cmd_o.op = OP_PAT_USE;  state_d = S_BIT;
      end
      S_BIT: begin
        if (sts_i.bit_set) begin
          cmd_o.op = OP_RD_ROOT;  state_d = S_CHK;
        end else begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (!sts_i.bit_zero) begin
          cmd_o.op = OP_BIT_DEC;  state_d = S_BIT;
        end else if (phase_q == PH_INIT_USE) begin
          cmd_o.op = OP_PAT_REM;  phase_d = PH_INIT_REM;  state_d = S_BIT;
        end else if (phase_q == PH_INIT_REM) begin
          cmd_o.op = OP_IX_CLR;  phase_d = PH_INIT_REL;  state_d = S_REL;
        end else begin
          state_d = S_OUT_CHUNK;
        end
      end
      S_CHK: begin
        if (!sts_i.fit) begin
          if (phase_q == PH_ALLOC) begin
            cmd_o.op = OP_IX_CLR;  phase_d = PH_ROLL;  state_d = S_REL;
          end else begin
            state_d = S_STEP;
          end
        end else if (sts_i.at_target) begin
          cmd_o.op = OP_TAKE_WR;  state_d = S_TUP;
        end else begin
          cmd_o.op = OP_RD_LEFT;  state_d = S_DESC;
        end
      end
      S_DESC: begin
        cmd_o.op = OP_DESCEND;  state_d = S_DCHK;
      end
      S_DCHK: begin
        if (sts_i.at_target) begin
          cmd_o.op = OP_TAKE_WR;  state_d = S_TUP;
        end else begin
          cmd_o.op = OP_RD_LEFT;  state_d = S_DESC;
        end
      end
      S_TUP: begin
        if (sts_i.at_root) begin
          state_d = S_STEP;
        end else begin
          cmd_o.op = OP_RD_SIB;  state_d = S_TUPW;
        end
      end
      S_TUPW: begin
        cmd_o.op = OP_UP_TAKE;  state_d = S_TUP;
      end
      S_REL: begin
        if (sts_i.ix_end) begin
          state_d = (phase_q == PH_ROLL) ? S_OUT_FAIL : S_OUT_ZERO;
        end else begin
          cmd_o.op = OP_LEAF_HELD;  state_d = S_FRD;
        end
      end
      S_FRD: begin
        cmd_o.op = OP_RD_NODE;  state_d = S_FCHK;
      end
      S_FCHK: begin
        if (sts_i.zero) begin
          if (phase_q == PH_QUERY) begin
            cmd_o.op = OP_SET_RES;  state_d = S_OUT_RES;
          end else begin
            cmd_o.op = OP_REL_WR;  state_d = S_RUP;
          end
        end else if (sts_i.at_root) begin
          state_d = (phase_q == PH_FREE || phase_q == PH_QUERY) ? S_OUT_FAIL : S_REL;
        end else begin
          cmd_o.op = OP_FIND_UP;  state_d = S_FRD;
        end
      end
      S_RUP: begin
        if (sts_i.at_root) begin
          state_d = (phase_q == PH_FREE) ? S_OUT_RES : S_REL;
        end else begin
          cmd_o.op = OP_RD_SIB;  state_d = S_RUPW;
        end
      end
      S_RUPW: begin
        cmd_o.op = OP_UP_REL;  state_d = S_RUP;
      end
      S_OUT_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;  state_d = S_IDLE;
        end
      end
      S_OUT_FAIL: begin
        cmd_o.status = (phase_q == PH_ROLL) ? ST_NO_SPACE : ST_NOT_ALLOC;
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;  state_d = S_IDLE;
        end
      end
      S_OUT_RES: begin
        cmd_o.kind = EM_RES;
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;  state_d = S_IDLE;
        end
      end
      S_OUT_CHUNK: begin
        cmd_o.kind = EM_CHUNK;
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (sts_i.chunk_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DISP) else $error("beat not dispatched");
  a_roll_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT_FAIL && phase_q != PH_ROLL |-> phase_q == PH_FREE || phase_q == PH_QUERY)
    else $error("failure in wrong phase");
  a_init_nopush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_TAKE_WR && phase_q == PH_INIT_REM |-> !cmd_o.push)
    else $error("reserved chunk recorded");

endmodule

@@ hdl/buddy_allocator_tree.sv @@
// Top level of the buddy allocator: controller plus datapath.
//
// Requests arrive as beats on the input channel (operation, unit_count,
// offset) and results leave as beats on the output channel (status,
// chunk_offset, chunk_size, last); both use valid/ready. An alloc for N
// units is split into power-of-two chunks, largest first, and gives one
// beat per chunk with last on the final one; if any chunk does not fit,
// the chunks already taken are released and a single no-space beat is
// given. Free, size query and init each give one beat.
// Items are handled one at a time. Every level of a walk down or up the tree
// takes a read of the single-port tree memory with registered read data.
// Init rewrites all 2047 nodes, one per cycle, before its reservation walks.
// After reset the block sweeps all 2047 nodes of the tree memory with
// in_ready_o low; configuration writes are taken at any time.
// A stalled receiver holds the output register; the block then waits at
// its next result beat and accepts no new input until that beat moves.
module buddy_allocator_tree import bat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [SizeW-1:0]  unit_count_i,
  input  logic [OffW-1:0]   offset_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [OffW-1:0]   chunk_offset_o,
  output logic [SizeW-1:0]  chunk_size_o,
  output logic              last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SizeW-1:0]  usable_units_i
);

  cmd_t cmd;
  sts_t sts;

  // The usable_units register can always take a write beat.
  assign cfg_ready_o = 1'b1;

  bat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bat_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .unit_count_i   (unit_count_i),
    .offset_i       (offset_i),
    .cfg_valid_i    (cfg_valid_i),
    .usable_units_i (usable_units_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .chunk_offset_o (chunk_offset_o),
    .chunk_size_o   (chunk_size_o),
    .last_o         (last_o)
  );

endmodule

@@ tb/sv/buddy_allocator_tree_tb.sv @@
// Self-checking testbench of the buddy allocator tree with a built-in tree predictor.
module buddy_allocator_tree_tb import bat_pkg::*;;

  // Stimulus and checking constants.
  localparam int unsigned HalfPeriod = 5;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 200;

  // One result beat as the predictor expects it.
  typedef struct packed {
    logic [1:0]       status;
    logic [OffW-1:0]  chunk_offset;
    logic [SizeW-1:0] chunk_size;
    logic             last;
  } result_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       operation_i = OPC_ALLOC;
  logic [SizeW-1:0] unit_count_i = '0;
  logic [OffW-1:0]  offset_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [1:0]       status_o;
  logic [OffW-1:0]  chunk_offset_o;
  logic [SizeW-1:0] chunk_size_o;
  logic             last_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] usable_units_i = '0;

  // Predictor state: largest free block under each node, and the register.
  logic [SizeW-1:0] largest_free [NodeCount];
  logic [SizeW-1:0] usable_reg;
  logic [OffW-1:0]  chunk_offsets [Slots];

  result_beat_t pending_results [$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  beats_sent = 0;
  int unsigned  beats_checked = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  // Live allocations, used to aim frees and queries at real blocks.
  logic [OffW-1:0] live_offsets [$];

  buddy_allocator_tree dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .unit_count_i   (unit_count_i),
    .offset_i       (offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .chunk_offset_o (chunk_offset_o),
    .chunk_size_o   (chunk_size_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .usable_units_i (usable_units_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Tree predictor. Nodes are numbered heap style from zero at the root;
  // every node holds the size of the largest free block below it.
  // ---------------------------------------------------------------------
  function automatic void tree_rebuild();
    int unsigned span;
    span = 2 * TotalUnits;
    for (int unsigned i = 0; i < NodeCount; i++) begin
      if (((i + 1) & i) == 0) begin
        span = span >> 1;
      end
      largest_free[i] = SizeW'(span);
    end
  endfunction

  // Leftmost-fit take of one power-of-two block; returns 0 when none fits.
  function automatic bit tree_take(int unsigned size, output int unsigned off);
    int unsigned idx;
    int unsigned span;
    idx = 0;
    off = 0;
    if (size == 0 || largest_free[0] < size) begin
      return 1'b0;
    end
    for (span = TotalUnits; span > size; span = span >> 1) begin
      idx = (largest_free[2 * idx + 1] >= size) ? 2 * idx + 1 : 2 * idx + 2;
    end
    largest_free[idx] = '0;
    off = (idx + 1) * span - TotalUnits;
    while (idx != 0) begin
      idx = (idx - 1) / 2;
      largest_free[idx] = (largest_free[2 * idx + 1] > largest_free[2 * idx + 2]) ?
                          largest_free[2 * idx + 1] : largest_free[2 * idx + 2];
    end
    return 1'b1;
  endfunction

  // Walks up from the leaf until it meets an allocated (zero) node.
  function automatic bit tree_find(int unsigned off, output int unsigned node,
                                   output int unsigned size);
    int unsigned idx;
    int unsigned span;
    idx = off + TotalUnits - 1;
    span = 1;
    node = 0;
    size = 0;
    while (largest_free[idx] != 0) begin
      if (idx == 0) begin
        return 1'b0;
      end
      idx = (idx - 1) / 2;
      span = span << 1;
    end
    node = idx;
    size = span;
    return 1'b1;
  endfunction

  // Releases the block covering an offset and merges buddies; returns a status.
  function automatic logic [1:0] tree_release(int unsigned off, output int unsigned blk_off,
                                              output int unsigned blk_size);
    int unsigned idx;
    int unsigned span;
    int unsigned left_v;
    int unsigned right_v;
    blk_off = 0;
    blk_size = 0;
    if (off >= TotalUnits) begin
      return ST_BAD_ARG;
    end
    if (!tree_find(off, idx, span)) begin
      return ST_NOT_ALLOC;
    end
    blk_off = (idx + 1) * span - TotalUnits;
    blk_size = span;
    largest_free[idx] = SizeW'(span);
    while (idx != 0) begin
      idx = (idx - 1) / 2;
      span = span << 1;
      left_v = largest_free[2 * idx + 1];
      right_v = largest_free[2 * idx + 2];
      largest_free[idx] = SizeW'((left_v + right_v == span) ? span :
                                 ((left_v > right_v) ? left_v : right_v));
    end
    return ST_OK;
  endfunction

  // Init: take the usable part as blocks, reserve the rest, then give back
  // the usable blocks so that only the reserved tail stays allocated.
  function automatic void tree_init();
    int unsigned held [$];
    int unsigned usable;
    int unsigned remaining;
    int unsigned off;
    int unsigned a;
    int unsigned b;
    usable = (usable_reg > TotalUnits) ? TotalUnits : usable_reg;
    tree_rebuild();
    remaining = usable;
    for (int unsigned s = TotalUnits; s != 0; s = s >> 1) begin
      if (remaining >= s) begin
        remaining -= s;
        if (tree_take(s, off)) begin
          held = {held, off};
        end
      end
    end
    remaining = TotalUnits - usable;
    for (int unsigned s = TotalUnits; s != 0; s = s >> 1) begin
      if (remaining >= s) begin
        remaining -= s;
        void'(tree_take(s, off));
      end
    end
    foreach (held[i]) begin
      void'(tree_release(held[i], a, b));
    end
  endfunction

  function automatic result_beat_t make_beat(logic [1:0] st, int unsigned off,
                                             int unsigned size, bit is_last);
    result_beat_t r;
    r.status = st;
    r.chunk_offset = OffW'(off);
    r.chunk_size = SizeW'(size);
    r.last = is_last;
    return r;
  endfunction

  // Appends one beat to the list of expected results.
  function automatic void add_expected(result_beat_t r);
    pending_results = {pending_results, r};
  endfunction

  // Works out the result beats of one request and queues them.
  function automatic void predict_request(logic [1:0] op, logic [SizeW-1:0] count,
                                          logic [OffW-1:0] off);
    int unsigned sizes [Slots];
    int unsigned taken;
    int unsigned got_off;
    int unsigned blk_off;
    int unsigned blk_size;
    int unsigned node;
    logic [1:0] st;
    bit failed;
    taken = 0;
    failed = 1'b0;
    case (op)
      OPC_ALLOC: begin
        if (count == 0) begin
          add_expected(make_beat(ST_OK, 0, 0, 1'b1));
        end else begin
          for (int b = Slots - 1; b >= 0; b--) begin
            if (count[b] && !failed) begin
              if (!tree_take(1 << b, got_off)) begin
                failed = 1'b1;
              end else begin
                chunk_offsets[taken] = OffW'(got_off);
                sizes[taken] = 1 << b;
                taken++;
              end
            end
          end
          if (failed) begin
            // Roll back the chunks that were already taken.
            for (int unsigned i = 0; i < taken; i++) begin
              void'(tree_release(chunk_offsets[i], blk_off, blk_size));
            end
            add_expected(make_beat(ST_NO_SPACE, 0, 0, 1'b1));
          end else begin
            for (int unsigned i = 0; i < taken; i++) begin
              add_expected(make_beat(ST_OK, chunk_offsets[i], sizes[i], i + 1 == taken));
              live_offsets = {live_offsets, chunk_offsets[i]};
            end
          end
        end
      end
      OPC_FREE: begin
        st = tree_release(off, blk_off, blk_size);
        add_expected(make_beat(st, blk_off, blk_size, 1'b1));
      end
      OPC_QUERY: begin
        if (!tree_find(off, node, blk_size)) begin
          add_expected(make_beat(ST_NOT_ALLOC, 0, 0, 1'b1));
        end else begin
          add_expected(make_beat(ST_OK, (node + 1) * blk_size - TotalUnits,
                                 blk_size, 1'b1));
        end
      end
      default: begin
        tree_init();
        add_expected(make_beat(ST_OK, 0, 0, 1'b1));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driving and checking.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_checked, what, got, want);
    error_count++;
  endtask

  // Sends one request beat; the prediction is made when the beat is accepted.
  // The request is driven on a falling edge after a random idle wait set by send_idle_pct.
  task automatic send_request(logic [1:0] op, logic [SizeW-1:0] count,
                              logic [OffW-1:0] off);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    unit_count_i <= count;
    offset_i <= off;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    predict_request(op, count, off);
    beats_sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // The receiver stalls at random; each accepted beat is checked at once.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (out_valid_o && out_ready_i && rst_ni) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, status", status_o, 0);
      end else begin
        automatic result_beat_t want = pending_results.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (chunk_offset_o !== want.chunk_offset) begin
          report_mismatch("chunk_offset", chunk_offset_o, want.chunk_offset);
        end
        if (chunk_size_o !== want.chunk_size) begin
          report_mismatch("chunk_size", chunk_size_o, want.chunk_size);
        end
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
      beats_checked++;
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Waits until every expected beat has arrived and the block has settled.
  task automatic wait_quiet();
    while (pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Writes the usable_units register while the block is idle.
  task automatic write_usable(logic [SizeW-1:0] value);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    usable_units_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    usable_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [OffW-1:0] pick_live_offset();
    if (live_offsets.size() == 0) begin
      return OffW'($urandom_range(TotalUnits - 1));
    end
    // An inner offset of a live block is as good as its start.
    return live_offsets[$urandom_range(live_offsets.size() - 1)] |
           OffW'($urandom_range(1) ? $urandom_range(3) : 0);
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------
  task automatic test_directed();
    send_request(OPC_ALLOC, '0, '0);            // zero-unit alloc
    send_request(OPC_QUERY, '0, '0);            // nothing allocated yet
    send_request(OPC_FREE, '0, 10'd1023);       // nothing allocated at top offset
    send_request(OPC_ALLOC, 11'd1024, '0);      // whole tree
    send_request(OPC_ALLOC, 11'd1, '0);         // no space left
    send_request(OPC_QUERY, '0, 10'd777);       // inner offset of the whole block
    send_request(OPC_FREE, '0, 10'd513);        // inner offset free
    send_request(OPC_ALLOC, 11'd2047, 10'h3FF); // larger than the tree, rolled back
    send_request(OPC_ALLOC, 11'd1023, '0);      // ten chunks
    send_request(OPC_QUERY, '0, 10'd1022);
    send_request(OPC_FREE, '0, 10'd512);
    send_request(OPC_FREE, '0, 10'd512);        // double free
    send_request(OPC_ALLOC, 11'd1536, '0);      // bit 10 and 9: first chunk fails
    send_request(OPC_INIT, 11'h7FF, 10'h3FF);   // init with full usable size
    send_request(OPC_ALLOC, 11'd5, '0);
    live_offsets.delete();
    write_usable(11'd0);
    send_request(OPC_INIT, '0, '0);             // everything reserved
    send_request(OPC_ALLOC, 11'd1, '0);
    write_usable(11'd1);
    send_request(OPC_INIT, '0, '0);             // one usable unit
    send_request(OPC_ALLOC, 11'd1, '0);
    send_request(OPC_QUERY, '0, '0);
    write_usable(11'd2047);                     // above the tree acts as the whole
    send_request(OPC_INIT, '0, '0);
  endtask

  task automatic test_random(int unsigned count);
    logic [1:0] op;
    logic [SizeW-1:0] units;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        op = OPC_ALLOC;
        // Mostly small requests, sometimes any value of the field.
        units = (pick < 5) ? SizeW'($urandom()) : SizeW'($urandom_range(1, 64));
        send_request(op, units, OffW'($urandom()));
      end else if (pick < 80) begin
        send_request(OPC_FREE, SizeW'($urandom()), pick_live_offset());
      end else if (pick < 95) begin
        send_request(OPC_QUERY, SizeW'($urandom()),
                     (pick < 90) ? pick_live_offset() : OffW'($urandom()));
      end else begin
        live_offsets.delete();
        send_request(OPC_INIT, SizeW'($urandom()), OffW'($urandom()));
      end
    end
  endtask

  task automatic test_phase(int unsigned send_pct, int unsigned recv_pct,
                            logic [SizeW-1:0] usable);
    write_usable(usable);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    live_offsets.delete();
    send_request(OPC_INIT, '0, '0);
    test_random(100);
  endtask

  initial begin
    usable_reg = SizeW'(TotalUnits);
    tree_rebuild();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_phase(6, 74, 11'd1000);
    test_phase(74, 6, SizeW'($urandom_range(1, 1024)));
    test_phase(0, 0, 11'd1024);
    wait_quiet();
    $display("Covered %0d request beats and %0d result beats", beats_sent, beats_checked);
    $display("over directed cases and three idle mixes with varied usable sizes.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
